### hw/rtl/rer_pkg.sv
// rer_pkg: shared types, constants and the round/saturate function of the
// rotary embedding rotator. No dependencies.
`default_nettype none

package rer_pkg;

    localparam int SampleW    = 16;
    localparam int PosW       = 8;
    localparam int CfgW       = 9;
    localparam int FracBits   = 14;
    localparam int ProdW      = 2 * SampleW;
    localparam int SumW       = ProdW + 1;
    localparam int QueueDepth = 4;

    localparam logic [CfgW-1:0] HeadDimReset = 9'd128;

    typedef logic signed [SampleW-1:0] t_sample;

    localparam t_sample SampleMax = 16'sh7fff;
    localparam t_sample SampleMin = 16'sh8000;

    localparam logic signed [SumW-1:0] RoundHalf = SumW'(1) << (FracBits - 1);

    // one stored element with its angle
    typedef struct packed {
        t_sample x;
        t_sample c;
        t_sample s;
    } t_elem;

    // a complete pair: first-half partner plus second-half element
    typedef struct packed {
        t_elem           lo;
        t_elem           hi;
        logic [PosW-1:0] pos_lo;
        logic [PosW-1:0] pos_hi;
    } t_pair;

    typedef struct packed {
        t_sample val;
        logic    sat;
    } t_res;

    // q.14 to integer, halves toward +inf, then clip to 16 bits
    function automatic t_res round_sat(input logic signed [SumW-1:0] sum);
        logic signed [SumW-1:0]                  q;
        logic [SumW-FracBits-SampleW:0]          top;
        t_res                                    r;
        q   = sum + RoundHalf;
        top = q[SumW-1:FracBits+SampleW-1];
        if ((&top) || !(|top)) begin
            r.val = q[FracBits+SampleW-1:FracBits];
            r.sat = 1'b0;
        end else begin
            r.val = q[SumW-1] ? SampleMin : SampleMax;
            r.sat = 1'b1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/rer_in_if.sv
// rer_in_if: input channel of the rotator, one row element with its angle.
// Depends on rer_pkg.
`default_nettype none

interface rer_in_if;
    logic              valid;
    logic              ready;
    rer_pkg::t_sample  x_value;
    rer_pkg::t_sample  cos_value;
    rer_pkg::t_sample  sin_value;

    modport source (output valid, output x_value, output cos_value, output sin_value,
                    input ready);
    modport sink   (input valid, input x_value, input cos_value, input sin_value,
                    output ready);
endinterface

`default_nettype wire

### hw/rtl/rer_out_if.sv
// rer_out_if: result channel of the rotator, one rotated element per beat.
// Depends on rer_pkg.
`default_nettype none

interface rer_out_if;
    logic                        valid;
    logic                        ready;
    rer_pkg::t_sample            rotated_value;
    logic [rer_pkg::PosW-1:0]    position;
    logic                        saturated;
    logic                        last;

    modport source (output valid, output rotated_value, output position,
                    output saturated, output last, input ready);
    modport sink   (input valid, input rotated_value, input position,
                    input saturated, input last, output ready);
endinterface

`default_nettype wire

### hw/rtl/rer_front.sv
// rer_front: element counter and first-half store; turns second-half
// elements into complete pairs. Depends on rer_pkg and rer_in_if.
`default_nettype none

module rer_front #(
    parameter int MAX_HEAD_DIM = 256
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [rer_pkg::CfgW-1:0]   i_head_dim,
    rer_in_if.sink                          i_in,
    output logic                            o_push_valid,
    output rer_pkg::t_pair                  o_push_data,
    input  wire logic                       i_push_ready
);

    localparam int Depth   = MAX_HEAD_DIM / 2;
    localparam int AddrW   = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW    = (MAX_HEAD_DIM > 512) ? 9 : $clog2(MAX_HEAD_DIM);
    localparam int MaxEven = MAX_HEAD_DIM - (MAX_HEAD_DIM % 2);

    logic [CntW-1:0]            r_cnt, n_cnt;
    logic [8:0]                 hd_even, row_len, k9, k_eff, j9;
    logic [7:0]                 half;
    logic [9:0]                 k_inc;
    logic                       first, acc, in_ready;
    logic [AddrW-1:0]           addr;
    rer_pkg::t_elem             cur;

    rer_pkg::t_elem             r_store [Depth];
    rer_pkg::t_elem             r_rd;
    rer_pkg::t_elem             r_cur;
    logic [rer_pkg::PosW-1:0]   r_pos_lo, r_pos_hi;
    logic                       r_valid, n_valid;

    always_comb begin
        hd_even = {i_head_dim[8:1], 1'b0};
        priority if (hd_even < 9'd2) begin
            row_len = 9'd2;
        end else if (int'(hd_even) > MaxEven) begin
            row_len = 9'(MaxEven);
        end else begin
            row_len = hd_even;
        end
        half  = row_len[8:1];
        k9    = 9'(r_cnt);
        // a counter left past the row by a length change restarts the row
        k_eff = (k9 >= row_len) ? 9'd0 : k9;
        k_inc = {1'b0, k_eff} + 10'd1;
        n_cnt = (k_inc >= {1'b0, row_len}) ? '0 : CntW'(k_inc[8:0]);
        first = k_eff < {1'b0, half};
        j9    = k_eff - {1'b0, half};
        addr  = first ? AddrW'(k_eff) : AddrW'(j9);
        cur   = '{x: i_in.x_value, c: i_in.cos_value, s: i_in.sin_value};
    end

    assign in_ready   = !r_valid || i_push_ready;
    assign i_in.ready = in_ready;
    assign acc        = i_in.valid && in_ready;

    always_comb begin
        n_valid = r_valid;
        if (acc && !first) begin
            n_valid = 1'b1;
        end else if (i_push_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
            if (acc) begin
                r_cnt <= n_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && first) begin
            r_store[addr] <= cur;
        end
        if (acc && !first) begin
            r_rd     <= r_store[addr];
            r_cur    <= cur;
            r_pos_lo <= 8'(j9);
            r_pos_hi <= 8'(k_eff);
        end
    end

    assign o_push_valid = r_valid;
    assign o_push_data  = '{lo: r_rd, hi: r_cur, pos_lo: r_pos_lo, pos_hi: r_pos_hi};

`ifndef SYNTHESIS
    a_cnt_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> (9'(r_cnt) < $past(row_len)))
        else $error("element counter left the row");
`endif

endmodule

`default_nettype wire

### hw/rtl/rer_queue.sv
// rer_queue: short pair queue between the front and the arithmetic back end.
// Depends on rer_pkg.
`default_nettype none

module rer_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push_valid,
    input  rer_pkg::t_pair      i_push_data,
    output logic                o_push_ready,
    output logic                o_pop_valid,
    output rer_pkg::t_pair      o_pop_data,
    input  wire logic           i_pop_ready
);

    localparam int PtrW = $clog2(rer_pkg::QueueDepth);
    localparam int CntW = $clog2(rer_pkg::QueueDepth + 1);

    rer_pkg::t_pair     r_mem [rer_pkg::QueueDepth];
    logic [PtrW-1:0]    r_wp, r_rp;
    logic [CntW-1:0]    r_cnt;
    logic               push, pop;

    assign o_push_ready = r_cnt != CntW'(rer_pkg::QueueDepth);
    assign o_pop_valid  = r_cnt != '0;
    assign o_pop_data   = r_mem[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
        return (p == PtrW'(rer_pkg::QueueDepth - 1)) ? '0 : p + PtrW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= ptr_next(r_wp);
            end
            if (pop) begin
                r_rp <= ptr_next(r_rp);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + CntW'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - CntW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_push_data;
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CntW'(rer_pkg::QueueDepth))
        else $error("pair queue overfilled");
    a_push_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> (r_cnt != '0))
        else $error("pushed pair lost");
`endif

endmodule

`default_nettype wire

### hw/rtl/rer_back.sv
// rer_back: multiplies a pair, rounds and saturates both sums, and sends
// them as two beats. Depends on rer_pkg and rer_out_if.
`default_nettype none

module rer_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_pop_valid,
    input  rer_pkg::t_pair      i_pop_data,
    output logic                o_pop_ready,
    rer_out_if.source           o_out
);

    logic signed [rer_pkg::ProdW-1:0]   m_lo_c, m_hi_s, m_hi_c, m_lo_s;
    logic signed [rer_pkg::ProdW-1:0]   r_lo_c, r_hi_s, r_hi_c, r_lo_s;
    logic [rer_pkg::PosW-1:0]           r_p_pos_lo, r_p_pos_hi;
    logic                               r_p_valid;
    logic signed [rer_pkg::SumW-1:0]    sum0, sum1;
    rer_pkg::t_res                      res0, res1;

    rer_pkg::t_res                      r_res0, r_res1;
    logic [rer_pkg::PosW-1:0]           r_pos0, r_pos1;
    logic                               r_valid, r_phase;
    logic                               p_ready, r_free, r_load, out_acc;

    // lo uses its own angle for x[j], hi's angle for the cross term
    assign m_lo_c = i_pop_data.lo.x * i_pop_data.lo.c;
    assign m_hi_s = i_pop_data.hi.x * i_pop_data.lo.s;
    assign m_hi_c = i_pop_data.hi.x * i_pop_data.hi.c;
    assign m_lo_s = i_pop_data.lo.x * i_pop_data.hi.s;

    assign out_acc     = o_out.valid && o_out.ready;
    assign r_free      = !r_valid || (o_out.ready && r_phase);
    assign r_load      = r_p_valid && r_free;
    assign p_ready     = !r_p_valid || r_load;
    assign o_pop_ready = p_ready;

    always_comb begin
        sum0 = rer_pkg::SumW'(r_lo_c) - rer_pkg::SumW'(r_hi_s);
        sum1 = rer_pkg::SumW'(r_hi_c) + rer_pkg::SumW'(r_lo_s);
        res0 = rer_pkg::round_sat(sum0);
        res1 = rer_pkg::round_sat(sum1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_valid   <= 1'b0;
            r_phase   <= 1'b0;
        end else begin
            if (p_ready) begin
                r_p_valid <= i_pop_valid;
            end
            if (r_load) begin
                r_valid <= 1'b1;
                r_phase <= 1'b0;
            end else if (out_acc && r_phase) begin
                r_valid <= 1'b0;
                r_phase <= 1'b0;
            end else if (out_acc) begin
                r_phase <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pop_valid && p_ready) begin
            r_lo_c     <= m_lo_c;
            r_hi_s     <= m_hi_s;
            r_hi_c     <= m_hi_c;
            r_lo_s     <= m_lo_s;
            r_p_pos_lo <= i_pop_data.pos_lo;
            r_p_pos_hi <= i_pop_data.pos_hi;
        end
        if (r_load) begin
            r_res0 <= res0;
            r_res1 <= res1;
            r_pos0 <= r_p_pos_lo;
            r_pos1 <= r_p_pos_hi;
        end
    end

    assign o_out.valid         = r_valid;
    assign o_out.rotated_value = r_phase ? r_res1.val : r_res0.val;
    assign o_out.saturated     = r_phase ? r_res1.sat : r_res0.sat;
    assign o_out.position      = r_phase ? r_pos1 : r_pos0;
    assign o_out.last          = r_phase;

`ifndef SYNTHESIS
    a_phase_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> r_valid)
        else $error("second beat selected with no pair held");
    a_pair_whole: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && !o_out.last) |=> (o_out.valid && o_out.last))
        else $error("pair split on output");
`endif

endmodule

`default_nettype wire

### hw/rtl/rotary_embedding_rotator_unit.sv
// Rotary position embedding rotator, half-split form.
// Input channel i_in: one row element per beat with the cosine and sine of
// its position (Q1.14); rows follow each other back to back. Elements of the
// first half of a row are stored and give no result. Each second-half element
// j+half gives two beats on o_out: position j (last=0), then j+half (last=1),
// each rounded to an integer and clipped to 16 bits, saturated set on a clip.
// Row length comes from i_cfg_we/i_cfg_wdata (low bit ignored, at least 2, at
// most MAX_HEAD_DIM); write it only while the block is idle.
// Throughput: first-half beats are taken one per cycle unless a pair is held by
// a full queue; each second-half beat gives two output beats. Rows up to about
// two dozen elements average one result per cycle with no output stall; longer
// rows fall below that, since only about seven pairs are buffered to keep the
// output busy through a long first half. A pair's first result is offered
// after the front's pair register, a queue slot, the multiplier stage and the
// round stage; the second in the cycle after the first is taken. A 4-pair
// queue between the store and the multipliers absorbs output stalls; once it
// and the front's pair register are full, i_in.ready drops.
// Reset (synchronous, active low) clears the row position and sets the row
// length to 128; stored first-half elements are not cleared.
// Depends on rer_pkg, rer_in_if, rer_out_if, rer_front, rer_queue, rer_back.
`default_nettype none

module rotary_embedding_rotator_unit #(
    parameter int MAX_HEAD_DIM = 256
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [rer_pkg::CfgW-1:0]   i_cfg_wdata,
    rer_in_if.sink                          i_in,
    rer_out_if.source                       o_out
);

    logic [rer_pkg::CfgW-1:0]   r_head_dim;
    logic                       f_valid, f_ready, q_valid, q_ready;
    rer_pkg::t_pair             f_data, q_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_dim <= rer_pkg::HeadDimReset;
        end else if (i_cfg_we) begin
            r_head_dim <= i_cfg_wdata;
        end
    end

    rer_front #(
        .MAX_HEAD_DIM (MAX_HEAD_DIM)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_dim   (r_head_dim),
        .i_in         (i_in),
        .o_push_valid (f_valid),
        .o_push_data  (f_data),
        .i_push_ready (f_ready)
    );

    rer_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .i_push_data  (f_data),
        .o_push_ready (f_ready),
        .o_pop_valid  (q_valid),
        .o_pop_data   (q_data),
        .i_pop_ready  (q_ready)
    );

    rer_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (q_valid),
        .i_pop_data  (q_data),
        .o_pop_ready (q_ready),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire
